### rtl/assert_macros.svh
// Assertion macros used by the top level of the value noise unit.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

### rtl/vnoise_pkg.sv
// Shared types, widths, hash constants and the blend table entry function
// of the value noise unit. Depends on nothing.
package vnoise_pkg;

    localparam int LAT_W      = 32;
    localparam int VAL_W      = 32;
    localparam int SMOOTH_W   = 36;
    localparam int WEIGHT_W   = 17;
    localparam int BPROD_W    = 54;
    localparam int BSUM_W     = 55;
    localparam int GPROD_W    = 52;
    localparam int OUT_W      = 16;
    localparam int SEED_W     = 6;
    localparam int GAIN_W     = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam int LANES      = 16;
    localparam int OCTAVE_LAT = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN = 2'd1;

    localparam logic [SEED_W-1:0] SEED_RESET = 6'd10;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd12868;

    localparam logic [31:0] HASH_MUL = 32'd15731;
    localparam logic [31:0] HASH_ADD = 32'd789221;
    localparam logic [31:0] HASH_OFS = 32'd1376312589;
    localparam logic [31:0] VAL_ONE  = 32'h4000_0000;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;

    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    // (1 - cos(pi*k/2^bits)) / 2 in Q0.16, from a Taylor sine squared.
    function automatic logic [WEIGHT_W-1:0] blend_entry(int unsigned k, int unsigned bits);
        logic [63:0] th;
        logic [63:0] term;
        logic [63:0] s;
        longint      acc;
        th   = (PI_Q30 * 64'(k)) >> (bits + 1);
        term = th;
        acc  = longint'(th);
        term = ((((term * th) >> 30) * th) >> 30) / 64'd6;
        acc  = acc - longint'(term);
        term = ((((term * th) >> 30) * th) >> 30) / 64'd20;
        acc  = acc + longint'(term);
        term = ((((term * th) >> 30) * th) >> 30) / 64'd42;
        acc  = acc - longint'(term);
        term = ((((term * th) >> 30) * th) >> 30) / 64'd72;
        acc  = acc + longint'(term);
        term = ((((term * th) >> 30) * th) >> 30) / 64'd110;
        acc  = acc - longint'(term);
        term = ((((term * th) >> 30) * th) >> 30) / 64'd156;
        acc  = acc + longint'(term);
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > (longint'(1) << 30))
        begin
            acc = longint'(1) << 30;
        end
        s = 64'(acc);
        return WEIGHT_W'((s * s + (64'd1 << 43)) >> 44);
    endfunction

endpackage

### rtl/vnoise_hash.sv
// One lattice hash lane: four register stages from lattice point to Q2.30 value.
// Depends on vnoise_pkg.
module vnoise_hash
    import vnoise_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [SEED_W-1:0]       seed,
    input  logic [LAT_W-1:0]        lat_x,
    input  logic [LAT_W-1:0]        lat_y,
    output logic signed [VAL_W-1:0] value
);

    logic [31:0] n_next, n1_reg, n2_reg, n3_reg;
    logic [31:0] sq_reg, t_reg, r_next;
    logic [31:0] val_reg;

    always_comb
    begin
        n_next = lat_x + lat_y * 32'(seed);
        n_next = (n_next << 13) ^ n_next;
        r_next = n3_reg * t_reg + HASH_OFS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= n_next;
            n2_reg  <= n1_reg;
            sq_reg  <= n1_reg * n1_reg;
            n3_reg  <= n2_reg;
            t_reg   <= sq_reg * HASH_MUL + HASH_ADD;
            val_reg <= VAL_ONE - {1'b0, r_next[30:0]};
        end
    end

    assign value = $signed(val_reg);

endmodule

### rtl/vnoise_octave.sv
// One octave: 16 hash lanes over a 4x4 lattice patch, 3x3 smoothing,
// cosine blend in x then y, gain product. Depends on vnoise_pkg, vnoise_hash.
module vnoise_octave
    import vnoise_pkg::*;
#(
    parameter int OCTAVE         = 0,
    parameter int COS_TABLE_BITS = 8,
    parameter int FRAC_BITS      = 16
)
(
    input  logic                      clk,
    input  logic                      en,
    input  cfg_t                      cfg,
    input  logic signed [31:0]        coord_x,
    input  logic signed [31:0]        coord_y,
    output logic signed [GPROD_W-1:0] prod
);

    localparam int TABLE_SIZE = 1 << COS_TABLE_BITS;

    typedef logic [WEIGHT_W-1:0] table_t [TABLE_SIZE];

    function automatic table_t build_table();
        table_t t;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            t[k] = blend_entry(k, COS_TABLE_BITS);
        end
        return t;
    endfunction

    localparam table_t BLEND_TABLE = build_table();

    logic signed [63:0]         ext_x, ext_y;
    logic [LAT_W-1:0]           cx, cy;
    logic [FRAC_BITS-1:0]       frac_x, frac_y;
    logic [COS_TABLE_BITS-1:0]  idx_x, idx_y;
    logic signed [VAL_W-1:0]    lat_val [LANES];

    logic [WEIGHT_W-1:0]        fx_reg [5];
    logic [WEIGHT_W-1:0]        fy_reg [7];
    logic signed [SMOOTH_W-1:0] sm_next [4];
    logic signed [SMOOTH_W-1:0] sm_reg  [4];
    logic signed [BPROD_W-1:0]  xp_reg  [4];
    logic signed [SMOOTH_W-1:0] ix_reg  [2];
    logic signed [BPROD_W-1:0]  yp_reg  [2];
    logic signed [SMOOTH_W-1:0] ov_reg;
    logic signed [GPROD_W-1:0]  gp_reg;

    logic signed [17:0]         wxa, wxb, wya, wyb;
    logic signed [BSUM_W-1:0]   bx0, bx1, by;

    assign ext_x  = 64'(coord_x) <<< OCTAVE;
    assign ext_y  = 64'(coord_y) <<< OCTAVE;
    assign cx     = ext_x[FRAC_BITS +: LAT_W];
    assign cy     = ext_y[FRAC_BITS +: LAT_W];
    assign frac_x = ext_x[FRAC_BITS-1:0];
    assign frac_y = ext_y[FRAC_BITS-1:0];

    generate
        if (FRAC_BITS >= COS_TABLE_BITS)
        begin : g_idx_top
            assign idx_x = frac_x[FRAC_BITS-1 -: COS_TABLE_BITS];
            assign idx_y = frac_y[FRAC_BITS-1 -: COS_TABLE_BITS];
        end
        else
        begin : g_idx_pad
            assign idx_x = {frac_x, {(COS_TABLE_BITS-FRAC_BITS){1'b0}}};
            assign idx_y = {frac_y, {(COS_TABLE_BITS-FRAC_BITS){1'b0}}};
        end
    endgenerate

    // Lanes cover cx-1 .. cx+2 by cy-1 .. cy+2, row-major.
    for (genvar dy = 0; dy < 4; dy++)
    begin : g_row
        for (genvar dx = 0; dx < 4; dx++)
        begin : g_col
            vnoise_hash u_hash
            (
                .clk   (clk),
                .en    (en),
                .seed  (cfg.seed),
                .lat_x (cx + 32'(dx) - 32'd1),
                .lat_y (cy + 32'(dy) - 32'd1),
                .value (lat_val[dy*4 + dx])
            );
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sm_next[c] =
                SMOOTH_W'(lat_val[(c/2)*4 + (c%2)])
              + SMOOTH_W'(lat_val[(c/2)*4 + (c%2) + 2])
              + SMOOTH_W'(lat_val[(c/2 + 2)*4 + (c%2)])
              + SMOOTH_W'(lat_val[(c/2 + 2)*4 + (c%2) + 2])
              + ((SMOOTH_W'(lat_val[(c/2)*4 + (c%2) + 1])
                + SMOOTH_W'(lat_val[(c/2 + 2)*4 + (c%2) + 1])
                + SMOOTH_W'(lat_val[(c/2 + 1)*4 + (c%2)])
                + SMOOTH_W'(lat_val[(c/2 + 1)*4 + (c%2) + 2])) <<< 1)
              + (SMOOTH_W'(lat_val[(c/2 + 1)*4 + (c%2) + 1]) <<< 2);
        end
        wxa = $signed({1'b0, WEIGHT_W'(17'h10000 - fx_reg[4])});
        wxb = $signed({1'b0, fx_reg[4]});
        wya = $signed({1'b0, WEIGHT_W'(17'h10000 - fy_reg[6])});
        wyb = $signed({1'b0, fy_reg[6]});
        bx0 = BSUM_W'(xp_reg[0]) + BSUM_W'(xp_reg[1]) + BSUM_W'(32768);
        bx1 = BSUM_W'(xp_reg[2]) + BSUM_W'(xp_reg[3]) + BSUM_W'(32768);
        by  = BSUM_W'(yp_reg[0]) + BSUM_W'(yp_reg[1]) + BSUM_W'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg[0] <= BLEND_TABLE[idx_x];
            fy_reg[0] <= BLEND_TABLE[idx_y];
            for (int s = 1; s < 5; s++)
            begin
                fx_reg[s] <= fx_reg[s-1];
            end
            for (int s = 1; s < 7; s++)
            begin
                fy_reg[s] <= fy_reg[s-1];
            end
            sm_reg    <= sm_next;
            xp_reg[0] <= sm_reg[0] * wxa;
            xp_reg[1] <= sm_reg[1] * wxb;
            xp_reg[2] <= sm_reg[2] * wxa;
            xp_reg[3] <= sm_reg[3] * wxb;
            ix_reg[0] <= SMOOTH_W'(bx0 >>> 16);
            ix_reg[1] <= SMOOTH_W'(bx1 >>> 16);
            yp_reg[0] <= ix_reg[0] * wya;
            yp_reg[1] <= ix_reg[1] * wyb;
            ov_reg    <= SMOOTH_W'(by >>> 16);
            gp_reg    <= ov_reg * $signed({1'b0, cfg.gain});
        end
    end

    assign prod = gp_reg;

endmodule

### rtl/value_noise_2d_octaves_unit.sv
// Value noise unit top level: configuration, octave pipelines, octave sum and output.
// Depends on vnoise_pkg, vnoise_octave, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, coord_x, coord_y): one request is a signed
//   fixed-point coordinate pair with FRAC_BITS fractional bits.
//   Output channel (out_valid/out_ready, noise_value): one signed Q4.12 sample per
//   request, in request order, saturated to the 16-bit range.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 writes
//   the hash row multiplier, index 1 the shared gain; other indexes are dropped.
//   cfg_ready is always high; write only while no request is in flight.
// Timing:
//   Eleven register stages from acceptance to out_valid; one request per cycle
//   unless the output stalls. The stages are the four-stage lattice hash, smoothing,
//   two blend multiply/round pairs, the gain multiply and the sum stage.
// Stall and reset:
//   The whole pipeline advances as one; when the output holds a sample that is
//   not taken, every stage holds and in_ready drops, so nothing is lost.
//   Reset clears all valid bits and loads the default seed and gain.
`include "assert_macros.svh"

module value_noise_2d_octaves_unit
    import vnoise_pkg::*;
#(
    parameter int OCTAVE_COUNT   = 2,
    parameter int COS_TABLE_BITS = 8,
    parameter int FRAC_BITS      = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      coord_x,
    input  logic signed [31:0]      coord_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] noise_value,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int PIPE_DEPTH = OCTAVE_LAT + 1;
    localparam int TOTAL_W    = GPROD_W + 3;
    localparam int Q_W        = TOTAL_W - 34;

    logic [PIPE_DEPTH-1:0]       vld_reg;
    logic [SEED_W-1:0]           seed_reg;
    logic [GAIN_W-1:0]           gain_reg;
    logic signed [OUT_W-1:0]     noise_reg;
    logic signed [OUT_W-1:0]     noise_next;
    logic                        advance;
    cfg_t                        cfg;
    logic signed [GPROD_W-1:0]   oct_prod [OCTAVE_COUNT];
    logic signed [TOTAL_W-1:0]   total;
    logic signed [Q_W-1:0]       q;

    // Hold everything while a finished sample waits to be taken.
    assign advance   = !vld_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;
    assign cfg.seed  = seed_reg;
    assign cfg.gain  = gain_reg;

    for (genvar o = 0; o < OCTAVE_COUNT; o++)
    begin : g_oct
        vnoise_octave #(
            .OCTAVE         (o),
            .COS_TABLE_BITS (COS_TABLE_BITS),
            .FRAC_BITS      (FRAC_BITS)
        ) u_octave
        (
            .clk     (clk),
            .en      (advance),
            .cfg     (cfg),
            .coord_x (coord_x),
            .coord_y (coord_y),
            .prod    (oct_prod[o])
        );
    end

    // Sum the octaves, round away the 2^-34 weight, saturate to Q4.12.
    always_comb
    begin
        total = '0;
        for (int o = 0; o < OCTAVE_COUNT; o++)
        begin
            total = total + TOTAL_W'(oct_prod[o]);
        end
        q = Q_W'((total + (TOTAL_W'(1) <<< 33)) >>> 34);
        if (q > Q_W'(32767))
        begin
            noise_next = 16'sh7fff;
        end
        else if (q < -Q_W'(32768))
        begin
            noise_next = -16'sh8000;
        end
        else
        begin
            noise_next = OUT_W'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            seed_reg <= SEED_RESET;
            gain_reg <= GAIN_RESET;
        end
        else
        begin
            if (advance)
            begin
                vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SEED: seed_reg <= cfg_data[SEED_W-1:0];
                    CFG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            noise_reg <= noise_next;
        end
    end

    assign out_valid   = vld_reg[PIPE_DEPTH-1];
    assign noise_value = noise_reg;

    // An accepted request enters the first valid stage.
    `ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_reg[0])
    // A stalled pipeline keeps its valid pattern.
    `ASSERT_NEXT(a_stall_holds, !advance, $stable(vld_reg))

endmodule
